>>> design/mp3s2_pkg.sv
`default_nettype none

package mp3s2_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_MAX_HEIGHT  = 4096;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int PLANE_WIDTH_W  = 11;
  localparam int PLANE_HEIGHT_W = 13;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;

  localparam logic [PLANE_WIDTH_W-1:0]  RST_PLANE_WIDTH  = PLANE_WIDTH_W'(16);
  localparam logic [PLANE_HEIGHT_W-1:0] RST_PLANE_HEIGHT = PLANE_HEIGHT_W'(16);

  localparam int OFIFO_DEPTH = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_WIDTH  = 2'd0,
    REG_PLANE_HEIGHT = 2'd1,
    REG_PAD_ROWS     = 2'd2,
    REG_PAD_COLS     = 2'd3
  } cfg_reg_e;

endpackage

`default_nettype wire

>>> design/max_pool_3x3_stride2.sv
// 3x3 max pooling at stride 2 over a stream of channel planes.
// Samples arrive on the s_axis channel in raster order, one request per
// sample, and planes follow back to back. Each pooled value leaves on the
// m_axis channel; tuser marks the last output of an output row and tlast
// the last output of the plane. The configuration port sets the plane
// width, the plane height and optional one-sample zero padding of rows and
// columns; any write restarts the plane at its first sample.
// One sample is accepted per cycle while the output buffer has room. The
// column line memories are read at the edge that accepts a sample, and the
// compare and write-back take the next cycle, at whose end a completed
// window's result enters the output buffer. Throughput is one sample per
// cycle while there is room, set by the single read and write port of each
// line memory; back-to-back accesses to the same column are forwarded. A
// three-entry output buffer keeps input acceptance going while the receiver
// stalls; tready falls only once that buffer would fill.
// Reset restores the default configuration and the plane start; the line
// memories need no clearing, as every column is written before it is read.
`default_nettype none

module max_pool_3x3_stride2 #(
  parameter int MAX_WIDTH   = mp3s2_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = mp3s2_pkg::DEF_MAX_HEIGHT,
  parameter int SAMPLE_BITS = mp3s2_pkg::DEF_SAMPLE_BITS,
  parameter int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [mp3s2_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mp3s2_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // sample
  input  wire logic [DATA_W-1:0]                s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // pooled
  output logic [DATA_W-1:0]                     m_axis_tdata,
  // row_end
  output logic                                  m_axis_tuser,
  output logic                                  m_axis_tlast
);

  localparam int COL_W     = $clog2(MAX_WIDTH + 3);
  localparam int ROW_W     = $clog2(MAX_HEIGHT + 3);
  localparam int COL_DEPTH = (MAX_WIDTH - 1) / 2 + 1;
  localparam int JW        = $clog2(COL_DEPTH);
  localparam int ITEM_W    = SAMPLE_BITS + 2;

  logic [mp3s2_pkg::PLANE_WIDTH_W-1:0]  plane_width_q;
  logic [mp3s2_pkg::PLANE_HEIGHT_W-1:0] plane_height_q;
  logic                                 pad_rows_q, pad_cols_q;

  logic [31:0]      w_ext, h_ext;
  logic [COL_W-1:0] width_c, pw, outw_n, pcol, j_full;
  logic [ROW_W-1:0] height_c, ph, outh_n, prow, orow1;

  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic signed [SAMPLE_BITS-1:0] left_one_q, left_two_q;

  logic accept;
  logic signed [SAMPLE_BITS-1:0] cur, l1_eff, l2_eff, hm_a, hm0;
  logic          even_col, last_odd_col, have0, row_end0, plane_end0;
  logic [JW-1:0] j0;

  logic                          s1_valid_q, s1_have_q, s1_even_q, s1_ge2_q;
  logic                          s1_top_pad_q, s1_bottom_q, s1_row_end_q, s1_plane_end_q;
  logic signed [SAMPLE_BITS-1:0] s1_hm_q;
  logic [JW-1:0]                 s1_j_q;

  logic signed [SAMPLE_BITS-1:0] wpm_mem [COL_DEPTH];
  logic signed [SAMPLE_BITS-1:0] srm_mem [COL_DEPTH];
  logic signed [SAMPLE_BITS-1:0] wpm_rd_q, srm_rd_q, fwd_data_q;
  logic                          fwd_wpm_q, fwd_srm_q;

  logic signed [SAMPLE_BITS-1:0] wpm_eff, srm_eff, top, new_wpm, wr_data, res;
  logic                          s1_wr, wr_srm, wr_wpm, emit, room;
  logic [ITEM_W-1:0]             fifo_out;

  assign w_ext = 32'(plane_width_q);
  assign h_ext = 32'(plane_height_q);
  assign width_c = (w_ext == 32'd0) ? COL_W'(1) :
                   (w_ext > 32'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH) : COL_W'(w_ext);
  assign height_c = (h_ext == 32'd0) ? ROW_W'(1) :
                    (h_ext > 32'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT) : ROW_W'(h_ext);
  assign pw     = width_c + (pad_cols_q ? COL_W'(2) : COL_W'(0));
  assign ph     = height_c + (pad_rows_q ? ROW_W'(2) : ROW_W'(0));
  assign outw_n = (pw - COL_W'(1)) >> 1;
  assign outh_n = (ph - ROW_W'(1)) >> 1;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = room;

  assign cur    = s_axis_tdata[SAMPLE_BITS-1:0];
  assign l1_eff = (col_q == '0) ? '0 : left_one_q;
  assign l2_eff = (col_q == '0) ? '0 : left_two_q;
  assign pcol   = col_q + COL_W'(pad_cols_q);
  assign prow   = row_q + ROW_W'(pad_rows_q);

  assign even_col     = !pcol[0] && (pcol >= COL_W'(2));
  assign last_odd_col = pad_cols_q && (pcol == width_c) && pcol[0];
  assign have0        = even_col || last_odd_col;
  assign j_full       = even_col ? ((pcol >> 1) - COL_W'(1)) : (pcol >> 1);
  assign j0           = j_full[JW-1:0];

  always_comb begin
    hm_a = even_col ? l2_eff : '0;
    hm0  = (hm_a > l1_eff) ? hm_a : l1_eff;
    hm0  = (hm0 > cur) ? hm0 : cur;
  end

  assign orow1      = !prow[0] ? (prow >> 1) : ((prow >> 1) + ROW_W'(1));
  assign row_end0   = ((j_full + COL_W'(1)) == outw_n);
  assign plane_end0 = row_end0 && (orow1 == outh_n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_width_q  <= mp3s2_pkg::RST_PLANE_WIDTH;
      plane_height_q <= mp3s2_pkg::RST_PLANE_HEIGHT;
      pad_rows_q     <= 1'b0;
      pad_cols_q     <= 1'b0;
      col_q          <= '0;
      row_q          <= '0;
      left_one_q     <= '0;
      left_two_q     <= '0;
      s1_valid_q     <= 1'b0;
      fwd_wpm_q      <= 1'b0;
      fwd_srm_q      <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        fwd_wpm_q  <= wr_wpm && (s1_j_q == j0);
        fwd_srm_q  <= wr_srm && (s1_j_q == j0);
        left_two_q <= l1_eff;
        left_one_q <= cur;
        if (col_q + COL_W'(1) >= width_c) begin
          col_q <= '0;
          row_q <= (row_q + ROW_W'(1) >= height_c) ? '0 : row_q + ROW_W'(1);
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
      if (cfg_we_i) begin
        case (mp3s2_pkg::cfg_reg_e'(cfg_idx_i))
          mp3s2_pkg::REG_PLANE_WIDTH: begin
            plane_width_q <= cfg_data_i[mp3s2_pkg::PLANE_WIDTH_W-1:0];
          end
          mp3s2_pkg::REG_PLANE_HEIGHT: begin
            plane_height_q <= cfg_data_i[mp3s2_pkg::PLANE_HEIGHT_W-1:0];
          end
          mp3s2_pkg::REG_PAD_ROWS: begin
            pad_rows_q <= cfg_data_i[0];
          end
          mp3s2_pkg::REG_PAD_COLS: begin
            pad_cols_q <= cfg_data_i[0];
          end
          default: begin
            pad_cols_q <= pad_cols_q;
          end
        endcase
        col_q      <= '0;
        row_q      <= '0;
        left_one_q <= '0;
        left_two_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_have_q      <= have0;
      s1_even_q      <= !prow[0];
      s1_ge2_q       <= (prow >= ROW_W'(2));
      s1_top_pad_q   <= pad_rows_q && (prow == ROW_W'(1));
      s1_bottom_q    <= pad_rows_q && (prow == height_c);
      s1_row_end_q   <= row_end0;
      s1_plane_end_q <= plane_end0;
      s1_hm_q        <= hm0;
      s1_j_q         <= j0;
      fwd_data_q     <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_srm) begin
      srm_mem[s1_j_q] <= wr_data;
    end
    if (wr_wpm) begin
      wpm_mem[s1_j_q] <= wr_data;
    end
    if (accept) begin
      srm_rd_q <= srm_mem[j0];
      wpm_rd_q <= wpm_mem[j0];
    end
  end

  assign s1_wr  = s1_valid_q && s1_have_q;
  assign wr_srm = s1_wr && s1_even_q;
  assign wr_wpm = s1_wr && !s1_even_q;

  always_comb begin
    wpm_eff = fwd_wpm_q ? fwd_data_q : wpm_rd_q;
    srm_eff = fwd_srm_q ? fwd_data_q : srm_rd_q;
    top     = s1_top_pad_q ? '0 : srm_eff;
    new_wpm = (top > s1_hm_q) ? top : s1_hm_q;
    wr_data = s1_even_q ? s1_hm_q : new_wpm;
    if (s1_even_q) begin
      res = (wpm_eff > s1_hm_q) ? wpm_eff : s1_hm_q;
    end else begin
      res = (new_wpm > 0) ? new_wpm : '0;
    end
    emit = s1_wr && (s1_even_q ? s1_ge2_q : s1_bottom_q);
  end

  mp3s2_out_fifo #(
    .DATA_W (ITEM_W)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (emit),
    .push_data_i ({s1_plane_end_q, s1_row_end_q, res}),
    .inflight_i  (s1_valid_q),
    .room_o      (room),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (fifo_out)
  );

  assign m_axis_tdata = DATA_W'(fifo_out[SAMPLE_BITS-1:0]);
  assign m_axis_tuser = fifo_out[SAMPLE_BITS];
  assign m_axis_tlast = fifo_out[SAMPLE_BITS+1];

  a_plane_end_is_row_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("plane end without row end");

  a_cfg_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (col_q == '0) && (row_q == '0))
    else $error("configuration write did not restart the plane");

  a_fwd_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fwd_wpm_q && fwd_srm_q))
    else $error("forwarding to both line memories at once");

  a_emit_needs_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> $past(accept))
    else $error("result without an accepted sample");

endmodule

`default_nettype wire

>>> design/mp3s2_out_fifo.sv
`default_nettype none

module mp3s2_out_fifo #(
  parameter int DATA_W = 18
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] push_data_i,
  input  wire logic              inflight_i,
  output logic                   room_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [DATA_W-1:0]      data_o
);

  localparam int DEPTH = mp3s2_pkg::OFIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign room_o  = (32'(cnt_q) + 32'(inflight_i)) < DEPTH;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (32'(cnt_q) != DEPTH || pop))
    else $error("output buffer overflow");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= DEPTH)
    else $error("output buffer count out of range");

  a_hold_when_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(data_o))
    else $error("output request changed while stalled");

endmodule

`default_nettype wire

>>> test/max_pool_3x3_stride2_tb.sv
module max_pool_3x3_stride2_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COL_DEPTH    = (mp3s2_pkg::DEF_MAX_WIDTH - 1) / 2 + 1;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [15:0] pooled;
    logic        row_end;
    logic        plane_end;
  } pool_result_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [mp3s2_pkg::CFG_IDX_W-1:0]  cfg_idx_i = mp3s2_pkg::REG_PLANE_WIDTH;
  logic [mp3s2_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [15:0]                      s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [15:0]                      m_axis_tdata;
  logic                             m_axis_tuser;
  logic                             m_axis_tlast;

  // Pooling state kept alongside the block.
  logic [10:0]        cfg_width = 11'd16;
  logic [12:0]        cfg_height = 13'd16;
  logic               cfg_pad_rows = 1'b0;
  logic               cfg_pad_cols = 1'b0;
  logic signed [15:0] prev_one = '0;
  logic signed [15:0] prev_two = '0;
  logic signed [15:0] partial_max [COL_DEPTH];
  logic signed [15:0] even_row_max [COL_DEPTH];
  int unsigned        col_pos = 0;
  int unsigned        row_pos = 0;

  logic [15:0]        sample_q [$];
  pool_result_t       pooled_q [$];
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_stall_pct = 0;
  int unsigned        hold_left = 0;
  int unsigned        cycle_count = 0;
  int unsigned        error_count = 0;
  int unsigned        samples_sent = 0;
  int unsigned        results_checked = 0;
  int unsigned        settings_used = 0;

  max_pool_3x3_stride2 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // sample
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // pooled
    .m_axis_tuser  (m_axis_tuser),   // row_end
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic signed [15:0] smax(input logic signed [15:0] a,
                                              input logic signed [15:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic void apply_config(input mp3s2_pkg::cfg_reg_e idx,
                                       input logic [12:0] data);
    case (idx)
      mp3s2_pkg::REG_PLANE_WIDTH:  cfg_width = data[10:0];
      mp3s2_pkg::REG_PLANE_HEIGHT: cfg_height = data;
      mp3s2_pkg::REG_PAD_ROWS:     cfg_pad_rows = data[0];
      mp3s2_pkg::REG_PAD_COLS:     cfg_pad_cols = data[0];
      default: ;
    endcase
    prev_one = '0;
    prev_two = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic void pool_sample(input logic signed [15:0] cur);
    int unsigned        w, h, pc, pr, pw, ph, outw, outh, pcol, prow, j, orow;
    logic signed [15:0] hm, res;
    bit                 have, emit;
    pool_result_t       r;
    w = (cfg_width == 0) ? 1 :
        (cfg_width > mp3s2_pkg::DEF_MAX_WIDTH) ? mp3s2_pkg::DEF_MAX_WIDTH : cfg_width;
    h = (cfg_height == 0) ? 1 :
        (cfg_height > mp3s2_pkg::DEF_MAX_HEIGHT) ? mp3s2_pkg::DEF_MAX_HEIGHT : cfg_height;
    pc = cfg_pad_cols;
    pr = cfg_pad_rows;
    pw = w + 2 * pc;
    ph = h + 2 * pr;
    outw = (pw >= 3) ? (pw - 3) / 2 + 1 : 0;
    outh = (ph >= 3) ? (ph - 3) / 2 + 1 : 0;
    have = 1'b0;
    emit = 1'b0;
    hm = '0;
    res = '0;
    j = 0;
    orow = 0;
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    pcol = col_pos + pc;
    prow = row_pos + pr;
    if (col_pos == 0) begin
      prev_one = '0;
      prev_two = '0;
    end
    if (pcol >= 2 && pcol % 2 == 0) begin
      hm = smax(smax(prev_two, prev_one), cur);
      j = (pcol - 2) / 2;
      have = 1'b1;
    end else if (pc != 0 && pcol == w && pcol % 2 == 1) begin
      hm = smax(smax(prev_one, cur), 16'sd0);
      j = (pcol - 1) / 2;
      have = 1'b1;
    end
    prev_two = prev_one;
    prev_one = cur;
    if (have && j < COL_DEPTH) begin
      if (prow % 2 == 0) begin
        if (prow >= 2) begin
          res = smax(partial_max[j], hm);
          orow = (prow - 2) / 2;
          emit = 1'b1;
        end
        even_row_max[j] = hm;
      end else begin
        partial_max[j] = smax((pr != 0 && prow == 1) ? 16'sd0 : even_row_max[j], hm);
        if (pr != 0 && prow == h) begin
          res = smax(partial_max[j], 16'sd0);
          orow = (prow - 1) / 2;
          emit = 1'b1;
        end
      end
    end
    if (emit) begin
      r.pooled = res;
      r.row_end = (j + 1 == outw);
      r.plane_end = (j + 1 == outw) && (orow + 1 == outh);
      pooled_q.push_back(r);
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  function automatic logic [15:0] pick_sample(input bit neg_only);
    if (neg_only) return 16'h8000 | 16'($urandom);
    case ($urandom_range(5))
      0:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      1:       return 16'($urandom_range(15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_samples(input int unsigned count, input bit neg_only);
    repeat (count) sample_q.push_back(pick_sample(neg_only));
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || s_axis_tvalid || pooled_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input mp3s2_pkg::cfg_reg_e idx, input int unsigned value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[12:0];
    apply_config(idx, value[12:0]);
  endtask

  task automatic set_plane(input int unsigned w, input int unsigned h,
                           input bit pr, input bit pc);
    wait_idle();
    write_reg(mp3s2_pkg::REG_PLANE_WIDTH, w);
    write_reg(mp3s2_pkg::REG_PLANE_HEIGHT, h);
    write_reg(mp3s2_pkg::REG_PAD_ROWS, ($urandom_range(4095) << 1) | pr);
    write_reg(mp3s2_pkg::REG_PAD_COLS, ($urandom_range(4095) << 1) | pc);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    settings_used++;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pool_sample(s_axis_tdata);
        samples_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= sample_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i) begin
    pool_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pooled_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result: expected none, actual pooled %h row_end %b plane_end %b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          want = pooled_q.pop_front();
          results_checked++;
          if (m_axis_tdata !== want.pooled || m_axis_tuser !== want.row_end ||
              m_axis_tlast !== want.plane_end) begin
            error_count++;
            $display("%0t: mismatch: expected pooled %h row_end %b plane_end %b, actual %h %b %b",
                     $time, want.pooled, want.row_end, want.plane_end,
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
          end
        end
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned w, h, n, random_items, phase;
    bit          pr, pc, neg_only;
    for (int i = 0; i < COL_DEPTH; i++) begin
      partial_max[i] = '0;
      even_row_max[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_idling(0, 0);
    set_plane(3, 3, 1'b0, 1'b0);
    sample_q = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF,
                 16'h8000, 16'h8000, 16'h8000, 16'h8000};
    set_plane(3, 2, 1'b1, 1'b0);
    sample_q = '{16'hFED4, 16'hFFFF, 16'hFFFE, 16'hFFF9, 16'hFFF7, 16'h8000};
    set_plane(1, 1, 1'b1, 1'b1);
    sample_q = '{16'hFFFB};
    set_plane(2, 2, 1'b0, 1'b0);
    sample_q = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
    set_plane(0, 3, 1'b1, 1'b1);
    sample_q = '{16'h8001, 16'h0100, 16'hFFFF};

    set_plane(13'h1FFF, 0, 1'b1, 1'b1);
    push_samples(200, 1'b0);
    set_plane(3, 13'h1FFF, 1'b0, 1'b0);
    push_samples(21, 1'b0);

    // The receiver holds off for a long stretch so that the output buffer fills
    // and requests back up at the input.
    set_plane(20, 6, 1'b0, 1'b1);
    hold_left = 400;
    push_samples(120, 1'b0);

    random_items = 0;
    phase = 0;
    while (random_items < 550) begin
      if (phase == 0 || $urandom_range(99) < 85) begin
        if ($urandom_range(3) == 0) begin
          w = $urandom_range(13, 64);
          h = $urandom_range(1, 4);
        end else begin
          w = $urandom_range(1, 12);
          h = $urandom_range(1, 9);
        end
        pr = $urandom_range(1);
        pc = $urandom_range(1);
        set_plane(w, h, pr, pc);
      end else begin
        wait_idle();
      end
      case (phase % 4)
        0: set_idling(0, 0);
        1: set_idling(77, 0);
        2: set_idling(0, 77);
        default: set_idling(25, 25);
      endcase
      neg_only = ($urandom_range(3) == 0);
      n = ((w > 12) ? 1 : $urandom_range(1, 3)) * w * h;
      if ($urandom_range(99) < 30) n += $urandom_range(w * h - 1);
      push_samples(n, neg_only);
      random_items += n;
      phase++;
    end

    wait_idle();
    $display("summary: %0d samples over %0d plane settings, %0d pooled results checked",
             samples_sent, settings_used, results_checked);
    if (error_count == 0 && pooled_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
